### rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge.
`define KRLT_CHECK(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define KRLT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KRLT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/krlt_pkg.sv
`default_nettype none

package krlt_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_SEARCH  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_MAX     = 3'd3,
    CMD_REVERSE = 3'd4,
    CMD_DUMP    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] name;
    logic [15:0] grade;
  } record_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == '0) begin
      r = AW'(DEPTH - 1);
    end else begin
      r = p - AW'(1);
    end
    return r;
  endfunction

  // Ring address base + offset; offset stays below DEPTH where it is used.
  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] ofs);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, p} + {1'b0, ofs};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/keyed_record_list_table.sv
`default_nettype none
// Keyed record table: an ordered list of up to 32 records (key, name handle,
// grade), front to back, with insert, search, delete, max, reverse and dump.
// Command channel: command, key_id, name_ref and grade transfer at a rising
// edge with start high and busy low. Results come out on status, rec_id,
// rec_name_ref, rec_grade and last, each valid for one cycle with
// result_valid high; the receiver cannot stall and must take every one.
// Command flow, n = records held:
//   insert, reverse, and any command on an empty table: result in the cycle
//   after the transfer, busy never rises, next command the cycle after.
//   search/max: records live in one ring buffer with a read and a write
//   port, read one entry per cycle; a result at match position p (or n-1
//   for max) is registered from that entry's read data, busy drops with it.
//   dump: n results on consecutive cycles.
//   delete: as search, then the ring entries past the hit move down one per
//   cycle, m = n-1-p of them in front-to-back order and p after a reverse;
//   busy stays high from the result through the last move.
// Unknown command codes are dropped. Reset empties the table and restores
// front-to-back order; the record memory itself is not cleared.

`include "assert_macros.svh"

module keyed_record_list_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] key_id,
  input  wire logic [31:0] name_ref,
  input  wire logic [15:0] grade,
  output logic             result_valid,
  output logic [1:0]       status,
  output logic [31:0]      rec_id,
  output logic [31:0]      rec_name_ref,
  output logic [15:0]      rec_grade,
  output logic             last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  state_t state;

  krlt_pkg::record_t mem [krlt_pkg::DEPTH];
  krlt_pkg::record_t rd_data;
  krlt_pkg::record_t best;
  krlt_pkg::record_t ins_rec;
  krlt_pkg::record_t max_rec;
  krlt_pkg::cmd_t    op;

  logic [krlt_pkg::AW-1:0] base;
  logic [krlt_pkg::AW-1:0] scan_addr;
  logic [krlt_pkg::AW-1:0] pend_addr;
  logic [krlt_pkg::AW-1:0] sh_rd;
  logic [krlt_pkg::AW-1:0] wr_pend_addr;
  logic [krlt_pkg::AW-1:0] ins_addr;
  logic [krlt_pkg::AW-1:0] front_addr;
  logic [krlt_pkg::AW-1:0] mem_waddr;
  logic [krlt_pkg::AW-1:0] mem_raddr;
  logic [krlt_pkg::CW-1:0] count;
  logic [krlt_pkg::CW-1:0] issue_idx;
  logic [krlt_pkg::CW-1:0] pend_idx;
  logic [krlt_pkg::CW-1:0] moves_left;
  logic [31:0]             key_q;
  logic                    flipped;
  logic                    pend_valid;
  logic                    wr_pend;
  logic                    mem_we;
  krlt_pkg::record_t       mem_wdata;
  logic                    scan_hit;
  logic                    scan_end;

  assign busy = (state != ST_IDLE);

  // Ring layout: physical base .. base+count-1; flipped puts the front at the top end.
  assign ins_rec    = '{key: key_id, name: name_ref, grade: grade};
  assign ins_addr   = flipped ? krlt_pkg::ptr_add(base, count) : krlt_pkg::ptr_dec(base);
  assign front_addr = flipped ? krlt_pkg::ptr_add(base, count - krlt_pkg::ONE_C) : base;

  assign scan_hit = (rd_data.key == key_q);
  assign scan_end = (pend_idx == count - krlt_pkg::ONE_C);
  assign max_rec  = (pend_idx == '0 || rd_data.grade > best.grade) ? rd_data : best;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ins_addr;
    mem_wdata = ins_rec;
    mem_raddr = scan_addr;
    if (state == ST_SHIFT) begin
      mem_we    = wr_pend;
      mem_waddr = wr_pend_addr;
      mem_wdata = rd_data;
      mem_raddr = sh_rd;
    end else if (state == ST_IDLE && start && command == krlt_pkg::CMD_INSERT &&
                 count != krlt_pkg::DEPTH_C) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      base         <= '0;
      flipped      <= 1'b0;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      wr_pend      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      wr_pend      <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op        <= krlt_pkg::cmd_t'(command);
            key_q     <= key_id;
            scan_addr <= front_addr;
            issue_idx <= '0;
            last      <= 1'b1;
            unique case (command)
              krlt_pkg::CMD_INSERT: begin
                result_valid <= 1'b1;
                if (count == krlt_pkg::DEPTH_C) begin
                  status       <= krlt_pkg::STAT_FULL;
                  rec_id       <= '0;
                  rec_name_ref <= '0;
                  rec_grade    <= '0;
                end else begin
                  status       <= krlt_pkg::STAT_OK;
                  rec_id       <= key_id;
                  rec_name_ref <= name_ref;
                  rec_grade    <= grade;
                  count        <= count + krlt_pkg::ONE_C;
                  if (!flipped) begin
                    base <= ins_addr;
                  end
                end
              end
              krlt_pkg::CMD_SEARCH, krlt_pkg::CMD_DELETE,
              krlt_pkg::CMD_MAX, krlt_pkg::CMD_DUMP: begin
                if (count == '0) begin
                  result_valid <= 1'b1;
                  status       <= krlt_pkg::STAT_EMPTY;
                  rec_id       <= '0;
                  rec_name_ref <= '0;
                  rec_grade    <= '0;
                end else begin
                  state <= ST_SCAN;
                end
              end
              krlt_pkg::CMD_REVERSE: begin
                flipped      <= ~flipped;
                result_valid <= 1'b1;
                status       <= krlt_pkg::STAT_OK;
                rec_id       <= '0;
                rec_name_ref <= '0;
                rec_grade    <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        ST_SCAN: begin
          // Issue one read per cycle, front to back.
          if (issue_idx != count) begin
            pend_valid <= 1'b1;
            pend_idx   <= issue_idx;
            pend_addr  <= scan_addr;
            issue_idx  <= issue_idx + krlt_pkg::ONE_C;
            scan_addr  <= flipped ? krlt_pkg::ptr_dec(scan_addr) : krlt_pkg::ptr_inc(scan_addr);
          end
          if (pend_valid) begin
            unique case (op)
              krlt_pkg::CMD_DUMP: begin
                result_valid <= 1'b1;
                status       <= krlt_pkg::STAT_OK;
                rec_id       <= rd_data.key;
                rec_name_ref <= rd_data.name;
                rec_grade    <= rd_data.grade;
                last         <= scan_end;
                if (scan_end) begin
                  state      <= ST_IDLE;
                  pend_valid <= 1'b0;
                end
              end
              krlt_pkg::CMD_MAX: begin
                best <= max_rec;
                if (scan_end) begin
                  result_valid <= 1'b1;
                  status       <= krlt_pkg::STAT_OK;
                  rec_id       <= max_rec.key;
                  rec_name_ref <= max_rec.name;
                  rec_grade    <= max_rec.grade;
                  state        <= ST_IDLE;
                  pend_valid   <= 1'b0;
                end
              end
              default: begin
                if (scan_hit) begin
                  result_valid <= 1'b1;
                  status       <= krlt_pkg::STAT_OK;
                  rec_id       <= rd_data.key;
                  rec_name_ref <= rd_data.name;
                  rec_grade    <= rd_data.grade;
                  pend_valid   <= 1'b0;
                  if (op == krlt_pkg::CMD_DELETE) begin
                    // Close the gap: pull every later ring entry down by one.
                    state      <= ST_SHIFT;
                    sh_rd      <= krlt_pkg::ptr_inc(pend_addr);
                    moves_left <= flipped ? pend_idx : count - krlt_pkg::ONE_C - pend_idx;
                  end else begin
                    state <= ST_IDLE;
                  end
                end else if (scan_end) begin
                  result_valid <= 1'b1;
                  status       <= krlt_pkg::STAT_NOT_FOUND;
                  rec_id       <= '0;
                  rec_name_ref <= '0;
                  rec_grade    <= '0;
                  state        <= ST_IDLE;
                  pend_valid   <= 1'b0;
                end
              end
            endcase
          end
        end

        ST_SHIFT: begin
          if (moves_left != '0) begin
            wr_pend      <= 1'b1;
            wr_pend_addr <= krlt_pkg::ptr_dec(sh_rd);
            sh_rd        <= krlt_pkg::ptr_inc(sh_rd);
            moves_left   <= moves_left - krlt_pkg::ONE_C;
          end else if (!wr_pend) begin
            count <= count - krlt_pkg::ONE_C;
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `KRLT_CHECK(a_count_max, count <= krlt_pkg::DEPTH_C, "entry count above capacity")
  `KRLT_IMPLY(a_scan_bound, state == ST_SCAN, issue_idx <= count, "scan ran past the last entry")
  `KRLT_NEXT(a_dump_burst, result_valid && !last, result_valid, "dump burst broke off")
  `KRLT_IMPLY(a_full_status, result_valid && status == krlt_pkg::STAT_FULL,
              count == krlt_pkg::DEPTH_C, "full reported below capacity")

endmodule

`default_nettype wire

### bench/keyed_record_list_table_tb.sv
`default_nettype none

module keyed_record_list_table_tb;

  // Codes the block must drop without a reply.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS  = 105;
  localparam int FILL_AT       = 50;
  localparam int DRAIN_AT      = 100;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 3 * krlt_pkg::DEPTH + 16;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [31:0] nref;
    logic [15:0] grd;
    bit          drain;
  } table_command_t;

  typedef struct {
    krlt_pkg::status_t stat;
    krlt_pkg::record_t rec;
    logic              fin;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  command = krlt_pkg::CMD_INSERT;
  logic [31:0] key_id = '0;
  logic [31:0] name_ref = '0;
  logic [15:0] grade = '0;
  logic        busy;
  logic        result_valid;
  logic [1:0]  status;
  logic [31:0] rec_id;
  logic [31:0] rec_name_ref;
  logic [15:0] rec_grade;
  logic        last;

  table_command_t    cmd_backlog[$];
  table_reply_t      replies_due[$];
  krlt_pkg::record_t table_image[$];   // front of the table at index 0

  table_command_t next_cmd;
  int total_cmds;
  int n_sent = 0;
  int n_owed = 0;
  int n_seen = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_full = 0;
  int n_dumps = 0;
  int cycle_count = 0;
  logic [31:0] key_pool[8];

  keyed_record_list_table uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .key_id       (key_id),
    .name_ref     (name_ref),
    .grade        (grade),
    .result_valid (result_valid),
    .status       (status),
    .rec_id       (rec_id),
    .rec_name_ref (rec_name_ref),
    .rec_grade    (rec_grade),
    .last         (last)
  );

  always #10 clk = ~clk;

  function automatic void owe_reply(krlt_pkg::status_t stat, krlt_pkg::record_t rec, logic fin);
    table_reply_t r;
    r.stat = stat;
    r.rec  = rec;
    r.fin  = fin;
    replies_due.push_back(r);
    n_owed++;
  endfunction

  // Apply one transfer to the table image and queue the replies it causes.
  function automatic void run_table_command(logic [2:0] cmd, logic [31:0] key,
                                            logic [31:0] nref, logic [15:0] grd);
    krlt_pkg::record_t none;
    krlt_pkg::record_t rec;
    krlt_pkg::record_t flipped[$];
    int hit;
    int best;
    int i;
    none = '0;
    case (cmd)
      krlt_pkg::CMD_INSERT: begin
        if (table_image.size() >= krlt_pkg::DEPTH) begin
          n_full++;
          owe_reply(krlt_pkg::STAT_FULL, none, 1'b1);
        end else begin
          rec.key   = key;
          rec.name  = nref;
          rec.grade = grd;
          table_image.push_front(rec);
          owe_reply(krlt_pkg::STAT_OK, rec, 1'b1);
        end
      end
      krlt_pkg::CMD_SEARCH, krlt_pkg::CMD_DELETE: begin
        if (table_image.size() == 0) begin
          owe_reply(krlt_pkg::STAT_EMPTY, none, 1'b1);
        end else begin
          hit = -1;
          for (i = 0; i < table_image.size(); i++) begin
            if (hit < 0 && table_image[i].key == key) hit = i;
          end
          if (hit < 0) begin
            owe_reply(krlt_pkg::STAT_NOT_FOUND, none, 1'b1);
          end else begin
            owe_reply(krlt_pkg::STAT_OK, table_image[hit], 1'b1);
            if (cmd == krlt_pkg::CMD_DELETE) table_image.delete(hit);
          end
        end
      end
      krlt_pkg::CMD_MAX: begin
        if (table_image.size() == 0) begin
          owe_reply(krlt_pkg::STAT_EMPTY, none, 1'b1);
        end else begin
          // strict compare keeps the front-most of equal grades
          best = 0;
          for (i = 1; i < table_image.size(); i++) begin
            if (table_image[i].grade > table_image[best].grade) best = i;
          end
          owe_reply(krlt_pkg::STAT_OK, table_image[best], 1'b1);
        end
      end
      krlt_pkg::CMD_REVERSE: begin
        foreach (table_image[j]) flipped.push_front(table_image[j]);
        table_image = flipped;
        owe_reply(krlt_pkg::STAT_OK, none, 1'b1);
      end
      krlt_pkg::CMD_DUMP: begin
        n_dumps++;
        if (table_image.size() == 0) begin
          owe_reply(krlt_pkg::STAT_EMPTY, none, 1'b1);
        end else begin
          for (i = 0; i < table_image.size(); i++) begin
            owe_reply(krlt_pkg::STAT_OK, table_image[i], i == table_image.size() - 1);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int sender_idle_pct();
    int phase;
    phase = (n_sent * 4) / total_cmds;
    case (phase)
      1: return 55;
      3: return 19;
      default: return 0;
    endcase
  endfunction

  function automatic void queue_cmd(logic [2:0] cmd, logic [31:0] key, logic [31:0] nref,
                                    logic [15:0] grd, bit drain);
    table_command_t c;
    c.cmd   = cmd;
    c.key   = key;
    c.nref  = nref;
    c.grd   = grd;
    c.drain = drain;
    cmd_backlog.push_back(c);
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  // Driver: present a command, hold it until busy is low, then advance.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        run_table_command(command, key_id, name_ref, grade);
        n_sent++;
      end
      if (result_valid) n_seen++;
      if (!(start && busy)) begin
        if (cmd_backlog.size() != 0 && !(cmd_backlog[0].drain && n_owed != n_seen)
            && $urandom_range(99) >= sender_idle_pct()) begin
          next_cmd = cmd_backlog.pop_front();
          start    <= 1'b1;
          command  <= next_cmd.cmd;
          key_id   <= next_cmd.key;
          name_ref <= next_cmd.nref;
          grade    <= next_cmd.grd;
        end else begin
          start    <= 1'b0;
          command  <= 3'($urandom_range(7));
          key_id   <= $urandom();
          name_ref <= $urandom();
          grade    <= 16'($urandom());
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest reply owed.
  always @(posedge clk) begin
    table_reply_t exp_reply;
    if (!rst && result_valid) begin
      if (replies_due.size() == 0) begin
        $error("unexpected result: status %0d rec_id %h", status, rec_id);
        n_errors++;
      end else begin
        exp_reply = replies_due.pop_front();
        n_checked++;
        if (status !== exp_reply.stat) begin
          $error("status: expected %0d, got %0d", exp_reply.stat, status);
          n_errors++;
        end
        if (rec_id !== exp_reply.rec.key) begin
          $error("rec_id: expected %h, got %h", exp_reply.rec.key, rec_id);
          n_errors++;
        end
        if (rec_name_ref !== exp_reply.rec.name) begin
          $error("rec_name_ref: expected %h, got %h", exp_reply.rec.name, rec_name_ref);
          n_errors++;
        end
        if (rec_grade !== exp_reply.rec.grade) begin
          $error("rec_grade: expected %h, got %h", exp_reply.rec.grade, rec_grade);
          n_errors++;
        end
        if (last !== exp_reply.fin) begin
          $error("last: expected %0b, got %0b", exp_reply.fin, last);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int counted;
    int r;
    int w;
    bit filled;
    logic [2:0] cmd;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < 8; k++) key_pool[k] = $urandom();

    // empty table, a reverse there and back, dropped codes
    queue_cmd(krlt_pkg::CMD_DUMP,    '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_SEARCH,  '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_DELETE,  '1, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_MAX,     '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_REVERSE, '0, '0, '0, 1'b0);
    queue_cmd(CMD_SPARE_A, '1, '1, '1, 1'b0);
    queue_cmd(CMD_SPARE_B, '1, '1, '1, 1'b0);
    queue_cmd(krlt_pkg::CMD_REVERSE, '0, '0, '0, 1'b0);
    // field extremes, duplicate key, tied top grade
    queue_cmd(krlt_pkg::CMD_INSERT,  '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_INSERT,  '1, '1, '1, 1'b0);
    queue_cmd(krlt_pkg::CMD_INSERT,  '0, 32'hA5A5_5A5A, '1, 1'b0);
    queue_cmd(krlt_pkg::CMD_MAX,     '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_SEARCH,  '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_SEARCH,  32'h1234_5678, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_DUMP,    '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_REVERSE, '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_MAX,     '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_SEARCH,  '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_DUMP,    '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_DELETE,  '1, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_DELETE,  32'h1234_5678, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_INSERT,  32'h8000_0001, 32'h0F0F_F0F0, 16'h8001, 1'b0);
    queue_cmd(krlt_pkg::CMD_DUMP,    '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_DELETE,  '0, '0, '0, 1'b0);
    queue_cmd(krlt_pkg::CMD_DUMP,    '0, '0, '0, 1'b0);

    counted = 0;
    filled = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      if (!filled && counted >= FILL_AT) begin
        // run the table past capacity, then walk it at full depth
        filled = 1'b1;
        for (int k = 0; k < krlt_pkg::DEPTH + 2; k++) begin
          queue_cmd(krlt_pkg::CMD_INSERT, pick_key(), $urandom(), 16'($urandom()), 1'b0);
        end
        queue_cmd(krlt_pkg::CMD_DUMP, '0, '0, '0, 1'b0);
        queue_cmd(krlt_pkg::CMD_MAX, '0, '0, '0, 1'b0);
        queue_cmd(krlt_pkg::CMD_REVERSE, '0, '0, '0, 1'b0);
        queue_cmd(krlt_pkg::CMD_DUMP, '0, '0, '0, 1'b0);
        queue_cmd(krlt_pkg::CMD_DELETE, pick_key(), '0, '0, 1'b0);
        counted += krlt_pkg::DEPTH + 7;
      end
      r = $urandom_range(99);
      if (r < 35) cmd = krlt_pkg::CMD_INSERT;
      else if (r < 50) cmd = krlt_pkg::CMD_SEARCH;
      else if (r < 70) cmd = krlt_pkg::CMD_DELETE;
      else if (r < 80) cmd = krlt_pkg::CMD_MAX;
      else if (r < 87) cmd = krlt_pkg::CMD_REVERSE;
      else if (r < 95) cmd = krlt_pkg::CMD_DUMP;
      else cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
      queue_cmd(cmd, pick_key(), $urandom(), 16'($urandom()),
                counted == 0 || counted == DRAIN_AT);
      if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) counted++;
    end
    total_cmds = cmd_backlog.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    for (w = 0; w < SETTLE_CYCLES && replies_due.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d results never arrived", replies_due.size());
    end

    $display("Sent %0d commands over four pacing phases, %0d dumps, %0d inserts refused as full.",
             n_sent, n_dumps, n_full);
    $display("Checked %0d results field by field, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
